// ----- hw/rtl/udpdmx_pkg.sv -----
// Package for the UDP port demultiplexer table: word types, codes and sizes.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none
package udpdmx_pkg;

  localparam int ENTRIES      = 8;
  localparam int HANDLER_BITS = 8;
  localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
  localparam logic [15:0] PORT_NONE     = 16'd0;

  localparam logic [1:0] FUNC_REGISTER = 2'd0;
  localparam logic [1:0] FUNC_CLEAR    = 2'd1;
  localparam logic [1:0] FUNC_RECEIVE  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BADARG    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_BADLEN    = 3'd4;
  localparam logic [2:0] ST_NOHANDLER = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] reg_port;
    logic [7:0]  handler_id;
    logic [31:0] src_addr;
    logic [15:0] hdr_src_port;
    logic [15:0] hdr_dst_port;
    logic [15:0] hdr_length;
    logic [15:0] buffer_len;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_handler;
    logic [31:0] out_src_addr;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [15:0] data_bytes;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } ctrl_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/udpdmx_ctrl.sv -----
// Controller state machine: sequences capture, execution and result delivery.
// Depends on udpdmx_pkg.
`default_nettype none
module udpdmx_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output udpdmx_pkg::dp_cmd_t    cmd
);
  import udpdmx_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_DONE: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/udpdmx_dp.sv -----
// Datapath: input word register, port table, parallel lookup and result register.
// Depends on udpdmx_pkg.
`default_nettype none
module udpdmx_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire udpdmx_pkg::dp_cmd_t  cmd,
  input  wire udpdmx_pkg::in_word_t in_data,
  output udpdmx_pkg::out_word_t     out_data
);
  import udpdmx_pkg::*;

  in_word_t                in_r;
  out_word_t               out_r, res_nxt;
  logic [ENTRIES-1:0]      valid_r;
  logic [15:0]             port_r    [ENTRIES];
  logic [HANDLER_BITS-1:0] handler_r [ENTRIES];

  logic [HANDLER_BITS-1:0] hid;
  logic [ENTRIES-1:0]      reg_hit, rcv_hit;
  logic                    reg_any, rcv_any, free_any;
  logic [IDX_W-1:0]        reg_idx, rcv_idx, free_idx;
  logic [HANDLER_BITS-1:0] found;
  logic                    wr_en, wr_new, clr;
  logic [IDX_W-1:0]        wr_idx;

  always_comb begin
    hid      = HANDLER_BITS'(in_r.handler_id);
    reg_any  = 1'b0;
    rcv_any  = 1'b0;
    free_any = 1'b0;
    reg_idx  = '0;
    rcv_idx  = '0;
    free_idx = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      reg_hit[k] = valid_r[k] && (port_r[k] == in_r.reg_port);
      rcv_hit[k] = valid_r[k] && (port_r[k] == in_r.hdr_dst_port);
    end
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (reg_hit[k]) begin
        reg_any = 1'b1;
        reg_idx = IDX_W'(k);
      end
      if (rcv_hit[k]) begin
        rcv_any = 1'b1;
        rcv_idx = IDX_W'(k);
      end
      if (!valid_r[k]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(k);
      end
    end
    found = rcv_any ? handler_r[rcv_idx] : '0;
  end

  always_comb begin
    res_nxt        = '0;
    wr_en          = 1'b0;
    wr_new         = 1'b0;
    clr            = 1'b0;
    wr_idx         = reg_idx;
    res_nxt.status = ST_BADARG;
    case (in_r.func)
      FUNC_REGISTER: begin
        if (in_r.reg_port == PORT_NONE || hid == '0) begin
          res_nxt.status = ST_BADARG;
        end else if (reg_any) begin
          wr_en          = 1'b1;
          res_nxt.status = ST_OK;
        end else if (free_any) begin
          wr_en          = 1'b1;
          wr_new         = 1'b1;
          wr_idx         = free_idx;
          res_nxt.status = ST_OK;
        end else begin
          res_nxt.status = ST_FULL;
        end
      end
      FUNC_CLEAR: begin
        clr            = 1'b1;
        res_nxt.status = ST_OK;
      end
      FUNC_RECEIVE: begin
        if (in_r.buffer_len < UDP_HDR_BYTES) begin
          res_nxt.status = ST_SHORT;
        end else if (in_r.hdr_length < UDP_HDR_BYTES ||
                     in_r.hdr_length > in_r.buffer_len) begin
          res_nxt.status = ST_BADLEN;
        end else begin
          res_nxt.out_dst_port = in_r.hdr_dst_port;
          if (found == '0) begin
            res_nxt.status = ST_NOHANDLER;
          end else begin
            res_nxt.status       = ST_OK;
            res_nxt.out_handler  = 8'(found);
            res_nxt.out_src_addr = in_r.src_addr;
            res_nxt.out_src_port = in_r.hdr_src_port;
            res_nxt.data_bytes   = in_r.hdr_length - UDP_HDR_BYTES;
          end
        end
      end
      default: res_nxt.status = ST_BADARG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.exec) begin
      if (clr) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.exec) begin
      out_r <= res_nxt;
      if (wr_en) begin
        handler_r[wr_idx] <= hid;
        if (wr_new) begin
          port_r[wr_idx] <= in_r.reg_port;
        end
      end
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// ----- hw/rtl/udp_port_demux_table_top.sv -----
// Top level of the UDP port demultiplexer table.
// Depends on udpdmx_pkg, udpdmx_ctrl and udpdmx_dp.
//
// The in_ channel carries one word per command: register a handler for a
// port, clear the table, or receive a UDP header. The out_ channel returns
// exactly one result word per command, in order: a status code and, for a
// successful receive, the handler, source address, source port and payload
// length. Both channels use valid and ready.
//
// Each word takes three steps in the controller's three-state sequence: capture
// in idle, the eight-entry parallel port compare and the table update in execute,
// and presentation of the result in done. After in_ready and in_valid are seen
// together, out_valid rises once the controller has passed through execute to
// done. in_ready is low until the current result is taken, so the block takes no
// new word before then and a stalled receiver holds the block with its result
// word unchanged. A synchronous reset on rst_n empties the table and returns
// the block to idle with in_ready high.
`default_nettype none
module udp_port_demux_table_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire udpdmx_pkg::in_word_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output udpdmx_pkg::out_word_t     out_data
);
  import udpdmx_pkg::*;

  dp_cmd_t cmd;

  udpdmx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  udpdmx_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ----- test/udp_port_demux_table_top_tb.sv -----
// Self-checking testbench for udp_port_demux_table_top: random and directed command words
// with random idling on both channels, results checked against an in-bench port table model.
// Depends on udpdmx_pkg and udp_port_demux_table_top.
`default_nettype none
module udp_port_demux_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import udpdmx_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 625;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int POOL_SIZE    = 12;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  in_word_t  cmd_q[$];
  out_word_t demux_results_q[$];

  logic                    tbl_used    [ENTRIES] = '{default: '0};
  logic [15:0]             tbl_port    [ENTRIES] = '{default: '0};
  logic [HANDLER_BITS-1:0] tbl_handler [ENTRIES] = '{default: '0};

  logic [15:0] port_pool [POOL_SIZE];

  int mismatches = 0;
  int words_in   = 0;
  int words_out  = 0;
  int tx_wait    = 0;
  int rx_wait    = 0;
  int st_seen [8] = '{default: 0};

  udp_port_demux_table_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial forever #10 clk = ~clk;

  function automatic out_word_t port_table_apply(in_word_t w);
    out_word_t               r;
    logic [HANDLER_BITS-1:0] hid;
    logic [HANDLER_BITS-1:0] found;
    bit                      done;
    r     = '0;
    hid   = w.handler_id[HANDLER_BITS-1:0];
    found = '0;
    done  = 1'b0;
    case (w.func)
      FUNC_REGISTER: begin
        if (w.reg_port == PORT_NONE || hid == '0) begin
          r.status = ST_BADARG;
        end else begin
          for (int k = 0; k < ENTRIES; k++) begin
            if (!done && tbl_used[k] && tbl_port[k] == w.reg_port) begin
              tbl_handler[k] = hid;
              done = 1'b1;
            end
          end
          for (int k = 0; k < ENTRIES; k++) begin
            if (!done && !tbl_used[k]) begin
              tbl_used[k]    = 1'b1;
              tbl_port[k]    = w.reg_port;
              tbl_handler[k] = hid;
              done = 1'b1;
            end
          end
          r.status = done ? ST_OK : ST_FULL;
        end
      end
      FUNC_CLEAR: begin
        for (int k = 0; k < ENTRIES; k++) begin
          tbl_used[k]    = 1'b0;
          tbl_port[k]    = '0;
          tbl_handler[k] = '0;
        end
        r.status = ST_OK;
      end
      FUNC_RECEIVE: begin
        if (w.buffer_len < UDP_HDR_BYTES) begin
          r.status = ST_SHORT;
        end else if (w.hdr_length < UDP_HDR_BYTES || w.hdr_length > w.buffer_len) begin
          r.status = ST_BADLEN;
        end else begin
          for (int k = 0; k < ENTRIES; k++) begin
            if (!done && tbl_used[k] && tbl_port[k] == w.hdr_dst_port) begin
              found = tbl_handler[k];
              done = 1'b1;
            end
          end
          r.out_dst_port = w.hdr_dst_port;
          if (found == '0) begin
            r.status = ST_NOHANDLER;
          end else begin
            r.status       = ST_OK;
            r.out_handler  = 8'(found);
            r.out_src_addr = w.src_addr;
            r.out_src_port = w.hdr_src_port;
            r.data_bytes   = w.hdr_length - UDP_HDR_BYTES;
          end
        end
      end
      default: r.status = ST_BADARG;
    endcase
    return r;
  endfunction

  function automatic in_word_t noise_word(logic [1:0] f);
    in_word_t w;
    w.func         = f;
    w.reg_port     = 16'($urandom);
    w.handler_id   = 8'($urandom);
    w.src_addr     = $urandom;
    w.hdr_src_port = 16'($urandom);
    w.hdr_dst_port = 16'($urandom);
    w.hdr_length   = 16'($urandom);
    w.buffer_len   = 16'($urandom);
    return w;
  endfunction

  task automatic push_register(logic [15:0] port, logic [7:0] hid);
    in_word_t w;
    w = noise_word(FUNC_REGISTER);
    w.reg_port   = port;
    w.handler_id = hid;
    cmd_q.push_back(w);
  endtask

  task automatic push_receive(logic [31:0] saddr, logic [15:0] sport, logic [15:0] dport,
                              logic [15:0] ulen, logic [15:0] blen);
    in_word_t w;
    w = noise_word(FUNC_RECEIVE);
    w.src_addr     = saddr;
    w.hdr_src_port = sport;
    w.hdr_dst_port = dport;
    w.hdr_length   = ulen;
    w.buffer_len   = blen;
    cmd_q.push_back(w);
  endtask

  task automatic task_check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    logic     nv;
    in_word_t nd;
    nv = in_valid;
    nd = in_data;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        demux_results_q.push_back(port_table_apply(in_data));
        void'(cmd_q.pop_front());
        words_in++;
        nv = 1'b0;
        tx_wait = ((words_in % 120) < 40) ? 0 : int'($urandom_range(0, 17));
      end
      if (!nv) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (cmd_q.size() != 0) begin
          nv = 1'b1;
          nd = cmd_q[0];
        end
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  always @(posedge clk) begin
    logic      nr;
    out_word_t want;
    nr = out_ready;
    if (!rst_n) begin
      nr = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (demux_results_q.size() == 0) begin
          $error("result word with nothing outstanding: status %0d", out_data.status);
          mismatches++;
        end else begin
          want = demux_results_q.pop_front();
          task_check_field("status", want.status, out_data.status);
          task_check_field("out_handler", want.out_handler, out_data.out_handler);
          task_check_field("out_src_addr", want.out_src_addr, out_data.out_src_addr);
          task_check_field("out_src_port", want.out_src_port, out_data.out_src_port);
          task_check_field("out_dst_port", want.out_dst_port, out_data.out_dst_port);
          task_check_field("data_bytes", want.data_bytes, out_data.data_bytes);
        end
        words_out++;
        st_seen[out_data.status]++;
        if (words_out == HOLD_AT) begin
          rx_wait = HOLD_CYCLES;
        end else begin
          rx_wait = ((words_out % 90) < 30) ? 0 : int'($urandom_range(0, 17));
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
    end
    out_ready <= nr;
  end

  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
    $display("FAIL udp_port_demux_table_top");
    $finish;
  end

  initial begin
    int          pick;
    int          blen;
    int          ulen;
    logic [15:0] port;
    logic [7:0]  hid;
    in_word_t    w;

    port_pool[0] = 16'd1;
    port_pool[1] = 16'hFFFF;
    port_pool[2] = 16'd53;
    port_pool[3] = 16'd80;
    for (int i = 4; i < POOL_SIZE; i++) begin
      port_pool[i] = 16'($urandom_range(1, 65535));
    end

    // Directed part: empty table, argument checks, rebinding, full table, length checks.
    push_receive(32'h0A000001, 16'd1234, 16'd80, 16'd20, 16'd20);
    push_register(PORT_NONE, 8'd5);
    push_register(16'd80, 8'd0);
    push_register(16'd80, 8'd1);
    push_register(16'd80, 8'hFF);
    push_register(16'hFFFF, 8'd2);
    push_register(16'd1, 8'd3);
    push_register(16'd2, 8'h80);
    push_register(16'd3, 8'h7F);
    push_register(16'd4, 8'd6);
    push_register(16'd5, 8'h55);
    push_register(16'd6, 8'hAA);
    push_register(16'd9999, 8'd9);
    push_register(16'd1, 8'd7);
    push_receive(32'h0, 16'd0, 16'd80, 16'd8, 16'd7);
    push_receive(32'h0, 16'd0, 16'd80, 16'd0, 16'd0);
    push_receive(32'h1, 16'd1, 16'd80, 16'd7, 16'd8);
    push_receive(32'h2, 16'd2, 16'd80, 16'd9, 16'd8);
    push_receive(32'h3, 16'd3, 16'd80, 16'd8, 16'd8);
    push_receive(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_receive(32'h4, 16'd4, PORT_NONE, 16'd100, 16'd200);
    cmd_q.push_back(noise_word(FUNC_UNUSED));
    cmd_q.push_back(noise_word(FUNC_CLEAR));
    push_receive(32'h5, 16'd5, 16'd80, 16'd30, 16'd40);
    push_register(16'hFFFF, 8'd1);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        port = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                           : port_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 24) == 0) port = PORT_NONE;
        hid = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom);
        push_register(port, hid);
      end else if (pick < 30) begin
        cmd_q.push_back(noise_word(FUNC_CLEAR));
      end else if (pick < 33) begin
        cmd_q.push_back(noise_word(FUNC_UNUSED));
      end else if (pick < 80) begin
        blen = $urandom_range(8, 65535);
        ulen = $urandom_range(8, blen);
        port = ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                           : port_pool[$urandom_range(0, POOL_SIZE - 1)];
        push_receive($urandom, 16'($urandom), port, 16'(ulen), 16'(blen));
      end else if (pick < 95) begin
        case ($urandom_range(0, 2))
          0: begin
            blen = $urandom_range(0, 7);
            ulen = $urandom_range(0, 65535);
          end
          1: begin
            blen = $urandom_range(8, 65535);
            ulen = $urandom_range(0, 7);
          end
          default: begin
            blen = $urandom_range(8, 65534);
            ulen = $urandom_range(blen + 1, 65535);
          end
        endcase
        port = port_pool[$urandom_range(0, POOL_SIZE - 1)];
        push_receive($urandom, 16'($urandom), port, 16'(ulen), 16'(blen));
      end else begin
        w = noise_word(2'($urandom));
        cmd_q.push_back(w);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || demux_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d command words and checked %0d result words, with one long receiver stall.",
             words_in, words_out);
    $display("Status counts: ok %0d, bad args %0d, full %0d, short %0d, bad length %0d,",
             st_seen[ST_OK], st_seen[ST_BADARG], st_seen[ST_FULL], st_seen[ST_SHORT],
             st_seen[ST_BADLEN]);
    $display("no handler %0d.", st_seen[ST_NOHANDLER]);
    if (mismatches == 0) begin
      $display("PASS udp_port_demux_table_top");
    end else begin
      $display("FAIL udp_port_demux_table_top");
    end
    $finish;
  end

endmodule
`default_nettype wire
